// ===== rtl/nopm_pkg.sv =====
// nopm_pkg: shared constants, payload types and helpers for the
// non-overlapping pattern matcher. No dependencies.
package nopm_pkg;

   // longest pattern and width of the internal occurrence counter
   localparam int MAX_PATTERN = 16;
   localparam int COUNT_WIDTH = 32;

   // fixed register and field widths
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int LEN_REG_WIDTH  = 5;
   localparam int OCC_WIDTH      = 32;

   // derived widths
   localparam int LEN_WIDTH  = $clog2(MAX_PATTERN + 1);
   localparam int IDX_WIDTH  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int WIN_DEPTH  = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PATTERN_LOW  = CSR_IDX_WIDTH'(0);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PATTERN_HIGH = CSR_IDX_WIDTH'(1);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PATTERN_LEN  = CSR_IDX_WIDTH'(2);

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0]           byte_out;
      logic                 match_end;
      logic [OCC_WIDTH-1:0] occurrences;
      logic                 text_done;
   } rsp_type;

   // active pattern as seen by the datapath
   typedef struct packed {
      logic [MAX_PATTERN-1:0][7:0] pattern;
      logic [LEN_WIDTH-1:0]        len;
   } cfg_type;

   // count reported on the 32-bit output, saturated
   function automatic logic [OCC_WIDTH-1:0] sat_occ(input logic [COUNT_WIDTH-1:0] count);
      logic [63:0] ext;
      ext = 64'(count);
      if (ext > 64'(32'hFFFF_FFFF)) begin
         return '1;
      end
      return ext[OCC_WIDTH-1:0];
   endfunction

endpackage

// ===== rtl/nonoverlapping_pattern_matcher.sv =====
// nonoverlapping_pattern_matcher: top level, suppression, occurrence count
// and result register. Depends on nopm_pkg, nopm_csr and nopm_window.
//
// usage
// - csr port: write csr_wdata to register csr_index when csr_we is high
//   (0 pattern bytes 0..7, 1 pattern bytes 8..15, 2 pattern length)
// - req channel: one text byte per beat, end_of_text on the last byte
// - rsp channel: one beat per text byte, the byte echoed with match_end,
//   the running count of accepted occurrences and text_done
// - the rsp beat is registered from the req beat; one byte per cycle is
//   sustained while rsp_ready stays high, the whole compare runs in the cycle the byte is taken
// - matches are leftmost and non-overlapping: after an accepted match the
//   next length-1 bytes cannot end another one
// - after the end_of_text beat the history, suppression and count clear
// - reset: pattern all zeros, length one, history and count empty
// - when rsp_ready is low the result register holds its beat; req_ready
//   stays high only while that register is empty or being drained
// - configure only while no beat is in flight
module nonoverlapping_pattern_matcher
   import nopm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data
);

   cfg_type cfg;
   logic    hit;
   logic    accept;
   logic    accepted;

   logic [IDX_WIDTH-1:0]   suppress_ff, suppress_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in, count_next;
   logic [IDX_WIDTH-1:0]   len_m1;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   nopm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nopm_window u_window (
      .clock     (clock),
      .reset     (reset),
      .advance   (accept),
      .clear     (accept && req_data.end_of_text),
      .text_byte (req_data.text_byte),
      .cfg       (cfg),
      .hit       (hit)
   );

   // result register empty or leaving this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign len_m1    = IDX_WIDTH'(cfg.len - LEN_WIDTH'(1));

   // suppression window and saturating count
   always_comb begin
      accepted    = 1'b0;
      suppress_in = suppress_ff;
      count_next  = count_ff;
      if (suppress_ff != '0) begin
         suppress_in = suppress_ff - IDX_WIDTH'(1);
      end else if (hit) begin
         accepted    = 1'b1;
         suppress_in = len_m1;
         if (count_ff != '1) begin
            count_next = count_ff + COUNT_WIDTH'(1);
         end
      end
      count_in = count_next;
      // end of text clears after the result is formed
      if (req_data.end_of_text) begin
         suppress_in = '0;
         count_in    = '0;
      end
   end

   always_comb begin
      rsp_in.byte_out    = req_data.text_byte;
      rsp_in.match_end   = accepted;
      rsp_in.occurrences = sat_occ(count_next);
      rsp_in.text_done   = req_data.end_of_text;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         suppress_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            suppress_ff <= suppress_in;
            count_ff    <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a flagged match always carries a nonzero count
   a_match_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.match_end |-> rsp_data.occurrences != '0)
      else $error("match_end with zero occurrence count");

   // end of text leaves nothing behind
   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.end_of_text |=> count_ff == '0 && suppress_ff == '0)
      else $error("state not cleared after end of text");

   // an accepted match bars the next length-1 bytes
   a_suppress_load: assert property (@(posedge clock) disable iff (reset)
      accept && accepted && !req_data.end_of_text |=> suppress_ff == $past(len_m1))
      else $error("suppression not loaded after accepted match");

   // no match is accepted while suppression runs
   a_no_match_suppressed: assert property (@(posedge clock) disable iff (reset)
      suppress_ff != '0 |-> !accepted)
      else $error("match accepted inside suppression window");

   // an empty result register never stalls the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

// ===== rtl/nopm_csr.sv =====
// nopm_csr: pattern and length registers with length clamping.
// Depends on nopm_pkg.
module nopm_csr
   import nopm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   output cfg_type                   cfg
);

   logic [63:0]              pat_low_ff;
   logic [63:0]              pat_high_ff;
   logic [LEN_REG_WIDTH-1:0] len_ff;
   logic [127:0]             pat_all;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         len_ff      <= LEN_REG_WIDTH'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_wdata;
            CSR_PATTERN_LEN:  len_ff      <= csr_wdata[LEN_REG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign pat_all = {pat_high_ff, pat_low_ff};

   // zero acts as one, anything past the maximum as the maximum
   always_comb begin
      cfg.pattern = pat_all[MAX_PATTERN*8-1:0];
      if (len_ff == '0) begin
         cfg.len = LEN_WIDTH'(1);
      end else if (32'(len_ff) > MAX_PATTERN) begin
         cfg.len = LEN_WIDTH'(MAX_PATTERN);
      end else begin
         cfg.len = LEN_WIDTH'(len_ff);
      end
   end

endmodule

// ===== rtl/nopm_window.sv =====
// nopm_window: history of recent text bytes and the parallel compare
// against the pattern. Depends on nopm_pkg.
module nopm_window
   import nopm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       clear,
   input  logic [7:0] text_byte,
   input  cfg_type    cfg,
   output logic       hit
);

   logic [7:0]           window_ff [WIN_DEPTH];
   logic [IDX_WIDTH-1:0] fill_ff;
   logic [IDX_WIDTH-1:0] fill_in;
   logic [MAX_PATTERN-1:0][7:0] cur;
   logic [MAX_PATTERN-1:0]      match_vec;
   logic [IDX_WIDTH-1:0]        len_m1;

   // cur[0] is the new byte, cur[j] the byte j positions back
   always_comb begin
      cur[0] = text_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         cur[j] = window_ff[j-1];
      end
   end

   // match_vec[l]: the last l+1 bytes equal pattern bytes 0..l
   always_comb begin
      for (int l = 0; l < MAX_PATTERN; l++) begin
         match_vec[l] = 1'b1;
         for (int k = 0; k <= l; k++) begin
            if (cur[l-k] != cfg.pattern[k]) begin
               match_vec[l] = 1'b0;
            end
         end
      end
   end

   assign len_m1 = IDX_WIDTH'(cfg.len - LEN_WIDTH'(1));
   assign hit    = (fill_ff >= len_m1) && match_vec[len_m1];

   always_comb begin
      fill_in = fill_ff;
      if (clear) begin
         fill_in = '0;
      end else if (advance && (32'(fill_ff) < MAX_PATTERN - 1)) begin
         fill_in = fill_ff + IDX_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // entries past the fill level are never compared, so no clearing
   always_ff @(posedge clock) begin
      if (advance) begin
         window_ff[0] <= text_byte;
         for (int j = 1; j < WIN_DEPTH; j++) begin
            window_ff[j] <= window_ff[j-1];
         end
      end
   end

endmodule

// ===== bench/tb_nonoverlapping_pattern_matcher.sv =====
// tb_nonoverlapping_pattern_matcher: self-checking bench for the non-overlapping
// pattern matcher, with its own scan predictor and randomized text streams.
// Depends on nopm_pkg and nonoverlapping_pattern_matcher.
`timescale 1ns / 100ps

module tb_nonoverlapping_pattern_matcher;
   import nopm_pkg::*;

   localparam int unsigned HALF_PERIOD = 10;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned SPAN_MAX    = 16;

   // dut inputs, all driven to known values from time zero
   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      csr_we    = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = CSR_PATTERN_LOW;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;

   // idle rates in percent, changed between test phases
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;

   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;

   // predictor copy of the registers
   logic [127:0] pattern_bits = '0;
   logic [4:0]   len_reg      = 5'd1;

   // predictor copy of the per-text state
   logic [7:0]  history [SPAN_MAX-1] = '{default: 8'h00};
   int unsigned bytes_seen  = 0;
   int unsigned hold_off    = 0;
   logic [31:0] occ_total   = '0;

   // scan results still owed by the block, oldest first
   rsp_type scan_results_due [$];

   nonoverlapping_pattern_matcher u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // run guard, a hang anywhere ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver backpressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // pattern length as the datapath sees it: 0 acts as 1, anything above 16 as 16
   function automatic int unsigned pattern_span();
      if (len_reg == 5'd0) begin
         return 1;
      end
      if (len_reg > 5'(SPAN_MAX)) begin
         return SPAN_MAX;
      end
      return int'(len_reg);
   endfunction

   function automatic logic [7:0] pattern_byte(input int unsigned k);
      return pattern_bits[8*k +: 8];
   endfunction

   // advance the scan state by one text byte and form the beat it owes
   function automatic rsp_type scan_text_byte(input req_type item);
      int unsigned span;
      logic        hit;
      logic        took;
      rsp_type     beat;
      span = pattern_span();
      hit  = 1'b0;
      took = 1'b0;
      // the newest byte closes the pattern, the window must hold the rest
      if (bytes_seen + 1 >= span && item.text_byte == pattern_byte(span - 1)) begin
         hit = 1'b1;
         for (int unsigned k = 0; k + 1 < span; k++) begin
            if (history[span - 2 - k] != pattern_byte(k)) begin
               hit = 1'b0;
            end
         end
      end
      // a match inside the shadow of the last accepted one is dropped
      if (hold_off > 0) begin
         hold_off--;
      end else if (hit) begin
         took     = 1'b1;
         hold_off = span - 1;
         if (occ_total != '1) begin
            occ_total++;
         end
      end
      beat.byte_out    = item.text_byte;
      beat.match_end   = took;
      beat.occurrences = occ_total;
      beat.text_done   = item.end_of_text;
      for (int k = SPAN_MAX - 2; k > 0; k--) begin
         history[k] = history[k - 1];
      end
      history[0] = item.text_byte;
      if (bytes_seen < SPAN_MAX - 1) begin
         bytes_seen++;
      end
      // end of text wipes window, shadow and count once the beat is formed
      if (item.end_of_text) begin
         history    = '{default: 8'h00};
         bytes_seen = 0;
         hold_off   = 0;
         occ_total  = '0;
      end
      return beat;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
      end
   endtask

   // result side: every rsp beat is held against the oldest owed result
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (scan_results_due.size() == 0) begin
            flag_mismatch("rsp beat with nothing owed", '0, 64'(rsp_data));
         end else begin
            want = scan_results_due.pop_front();
            if (rsp_data.byte_out !== want.byte_out) begin
               flag_mismatch("byte_out", 64'(want.byte_out), 64'(rsp_data.byte_out));
            end
            if (rsp_data.match_end !== want.match_end) begin
               flag_mismatch("match_end", 64'(want.match_end), 64'(rsp_data.match_end));
            end
            if (rsp_data.occurrences !== want.occurrences) begin
               flag_mismatch("occurrences", 64'(want.occurrences),
                             64'(rsp_data.occurrences));
            end
            if (rsp_data.text_done !== want.text_done) begin
               flag_mismatch("text_done", 64'(want.text_done), 64'(rsp_data.text_done));
            end
         end
      end
   end

   // one req beat: optional idle gap, then hold valid until the block takes it
   task automatic send_text_byte(input logic [7:0] text_byte, input logic last);
      req_type item;
      item.text_byte   = text_byte;
      item.end_of_text = last;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      scan_results_due.push_back(scan_text_byte(item));
   endtask

   // drop valid and let every owed beat come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (scan_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   // register write, only called with the block idle
   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PATTERN_LOW: begin
            pattern_bits[63:0] = data;
         end
         CSR_PATTERN_HIGH: begin
            pattern_bits[127:64] = data;
         end
         CSR_PATTERN_LEN: begin
            len_reg = data[4:0];
         end
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   function automatic logic random_last();
      return ($urandom_range(31) == 0);
   endfunction

   // out of reset: zero pattern of length one, so every 0x00 byte matches
   task automatic test_reset_defaults();
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'hFF, 1'b1);
   endtask

   // length register of zero behaves as length one
   task automatic test_zero_length();
      drain();
      write_reg(CSR_PATTERN_LOW, 64'h0000_0000_0000_00FF);
      write_reg(CSR_PATTERN_LEN, 64'd0);
      send_text_byte(8'hFF, 1'b0);
      send_text_byte(8'hFF, 1'b1);
   endtask

   // self-overlapping pattern: shadow drops every other match, and a fresh
   // text cannot match before the window refills
   task automatic test_overlap_shadow();
      drain();
      write_reg(CSR_PATTERN_LOW, 64'h0000_0000_0000_4141);
      write_reg(CSR_PATTERN_LEN, 64'd2);
      send_text_byte(8'h41, 1'b0);
      send_text_byte(8'h41, 1'b0);
      send_text_byte(8'h41, 1'b0);
      send_text_byte(8'h41, 1'b1);
      send_text_byte(8'h41, 1'b0);
      send_text_byte(8'h41, 1'b1);
   endtask

   // oversized length register clamps to sixteen, whole window in use
   task automatic test_full_span();
      int unsigned span;
      drain();
      write_reg(CSR_PATTERN_LOW,  64'h7F80_01FE_55AA_FF00);
      write_reg(CSR_PATTERN_HIGH, 64'h0F_F0_3C_C3_96_69_00_FF);
      write_reg(CSR_PATTERN_LEN,  64'hFFFF_FFFF_FFFF_FFFF);
      span = pattern_span();
      for (int unsigned k = 0; k < span; k++) begin
         send_text_byte(pattern_byte(k), k == span - 1);
      end
   endtask

   // random texts: mostly pattern copies and pattern symbols, some noise;
   // patterns change between segments without ending the text
   task automatic test_random_texts(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned n_items);
      int unsigned  sent;
      int unsigned  seg_end;
      int unsigned  n_sym;
      int unsigned  plen;
      int unsigned  roll;
      int unsigned  span;
      logic [7:0]   sym [3];
      logic [127:0] pat;
      logic [63:0]  len_word;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         n_sym = $urandom_range(3, 2);
         for (int k = 0; k < 3; k++) begin
            sym[k] = 8'($urandom_range(255));
         end
         // short patterns mostly, long ones and out-of-range lengths now and then
         roll = $urandom_range(99);
         if (roll < 55) begin
            plen = $urandom_range(4, 1);
         end else if (roll < 85) begin
            plen = $urandom_range(16, 5);
         end else if (roll < 92) begin
            plen = 0;
         end else begin
            plen = $urandom_range(31, 17);
         end
         pat = {$urandom, $urandom, $urandom, $urandom};
         for (int unsigned k = 0; k < SPAN_MAX; k++) begin
            if ($urandom_range(7) != 0) begin
               pat[8*k +: 8] = sym[$urandom_range(n_sym - 1)];
            end
         end
         len_word      = {$urandom, $urandom};
         len_word[4:0] = plen[4:0];
         drain();
         write_reg(CSR_PATTERN_LOW,  pat[63:0]);
         write_reg(CSR_PATTERN_HIGH, pat[127:64]);
         write_reg(CSR_PATTERN_LEN,  len_word);
         span    = pattern_span();
         seg_end = sent + $urandom_range(60, 20);
         while (sent < seg_end && sent < n_items) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
               for (int unsigned k = 0; k < span; k++) begin
                  send_text_byte(pattern_byte(k), random_last());
               end
               sent += span;
            end else if (roll < 85) begin
               send_text_byte(sym[$urandom_range(n_sym - 1)], random_last());
               sent++;
            end else begin
               send_text_byte(8'($urandom_range(255)), random_last());
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct    = 22;
      receiver_stall_pct = 22;
      test_reset_defaults();
      test_zero_length();
      test_overlap_shadow();
      test_full_span();

      // sender mostly busy with a slow receiver, then the reverse, then full rate
      test_random_texts(22, 86, 260);
      test_random_texts(86, 22, 260);
      test_random_texts(0, 0, 260);

      drain();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== nonoverlapping_pattern_matcher.f =====
rtl/nopm_pkg.sv
rtl/nopm_csr.sv
rtl/nopm_window.sv
rtl/nonoverlapping_pattern_matcher.sv
bench/tb_nonoverlapping_pattern_matcher.sv
